>>> design/strict_utf8_to_utf16_decoder_top_defines.svh
// assertion macros used by the checker file
`ifndef STRICT_UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH
`define STRICT_UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SU8U16_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SU8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/su8u16_pkg.sv
package su8u16_pkg;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	localparam logic [7:0] BOUND_LO  = 8'h80;
	localparam logic [7:0] BOUND_HI  = 8'hBF;
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD3_SUR = 8'hED;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;
	localparam logic [7:0] E0_LO     = 8'hA0;
	localparam logic [7:0] ED_HI     = 8'h9F;
	localparam logic [7:0] F0_LO     = 8'h90;
	localparam logic [7:0] F4_HI     = 8'h8F;

	// open-sequence state carried between bytes
	typedef struct packed {
		logic [1:0]  cont;
		logic [20:0] part;
		logic [7:0]  lo;
		logic [7:0]  hi;
	} dec_state_t;

	localparam dec_state_t ST_CLOSED = '{cont: 2'd0, part: 21'd0, lo: BOUND_LO, hi: BOUND_HI};

	// up to two code units caused by one byte
	typedef struct packed {
		logic [1:0]  n;
		logic [15:0] u0;
		logic        r0;
		logic [15:0] u1;
		logic        r1;
	} dec_result_t;

endpackage

>>> design/su8u16_dec.sv
module su8u16_dec (
	input  su8u16_pkg::dec_state_t  st,
	input  logic [7:0]              in_byte,
	input  logic                    final_byte,
	output su8u16_pkg::dec_state_t  nxt,
	output su8u16_pkg::dec_result_t res
);

	su8u16_pkg::dec_state_t f_st;
	logic        f_emit;
	logic [15:0] f_unit;
	logic        f_rep;
	logic        in_bounds;
	logic [20:0] acc;
	logic [19:0] off;

	// byte taken as the start of a new sequence
	always_comb begin
		f_st   = su8u16_pkg::ST_CLOSED;
		f_emit = 1'b0;
		f_unit = su8u16_pkg::REPL_UNIT;
		f_rep  = 1'b0;
		if (!in_byte[7]) begin
			f_emit = 1'b1;
			f_unit = {8'h00, in_byte};
		end else if (in_byte >= su8u16_pkg::LEAD2_MIN && in_byte <= su8u16_pkg::LEAD2_MAX) begin
			f_st.cont = 2'd1;
			f_st.part = {16'd0, in_byte[4:0]};
		end else if (in_byte >= su8u16_pkg::LEAD3_MIN && in_byte <= su8u16_pkg::LEAD3_MAX) begin
			f_st.cont = 2'd2;
			f_st.part = {17'd0, in_byte[3:0]};
			if (in_byte == su8u16_pkg::LEAD3_MIN) f_st.lo = su8u16_pkg::E0_LO;
			if (in_byte == su8u16_pkg::LEAD3_SUR) f_st.hi = su8u16_pkg::ED_HI;
		end else if (in_byte >= su8u16_pkg::LEAD4_MIN && in_byte <= su8u16_pkg::LEAD4_MAX) begin
			f_st.cont = 2'd3;
			f_st.part = {18'd0, in_byte[2:0]};
			if (in_byte == su8u16_pkg::LEAD4_MIN) f_st.lo = su8u16_pkg::F0_LO;
			if (in_byte == su8u16_pkg::LEAD4_MAX) f_st.hi = su8u16_pkg::F4_HI;
		end else begin
			f_emit = 1'b1;
			f_rep  = 1'b1;
		end
	end

	assign in_bounds = (in_byte >= st.lo) && (in_byte <= st.hi);
	assign acc       = {st.part[14:0], in_byte[5:0]};
	assign off       = 20'(acc - su8u16_pkg::SUPP_BASE);

	always_comb begin
		nxt    = st;
		res.n  = 2'd0;
		res.u0 = su8u16_pkg::REPL_UNIT;
		res.r0 = 1'b0;
		res.u1 = su8u16_pkg::REPL_UNIT;
		res.r1 = 1'b0;
		if (st.cont != 2'd0) begin
			if (in_bounds) begin
				if (st.cont == 2'd1) begin
					nxt = su8u16_pkg::ST_CLOSED;
					if (acc[20:16] == 5'd0) begin
						res.n  = 2'd1;
						res.u0 = acc[15:0];
					end else begin
						// supplementary scalar, surrogate pair
						res.n  = 2'd2;
						res.u0 = su8u16_pkg::HI_SURR | {6'd0, off[19:10]};
						res.u1 = su8u16_pkg::LO_SURR | {6'd0, off[9:0]};
					end
				end else begin
					nxt.cont = st.cont - 2'd1;
					nxt.part = acc;
					nxt.lo   = su8u16_pkg::BOUND_LO;
					nxt.hi   = su8u16_pkg::BOUND_HI;
				end
			end else begin
				// broken subpart, then the same byte as a fresh start
				res.n  = 2'd1;
				res.r0 = 1'b1;
				nxt    = f_st;
				if (f_emit) begin
					res.n  = 2'd2;
					res.u1 = f_unit;
					res.r1 = f_rep;
				end
			end
		end else begin
			nxt = f_st;
			if (f_emit) begin
				res.n  = 2'd1;
				res.u0 = f_unit;
				res.r0 = f_rep;
			end
		end
		if (final_byte) begin
			// cut-off sequence at the end of the string
			if (nxt.cont != 2'd0 && res.n != 2'd2) begin
				if (res.n == 2'd0) begin
					res.u0 = su8u16_pkg::REPL_UNIT;
					res.r0 = 1'b1;
				end else begin
					res.u1 = su8u16_pkg::REPL_UNIT;
					res.r1 = 1'b1;
				end
				res.n = res.n + 2'd1;
			end
			nxt = su8u16_pkg::ST_CLOSED;
		end
	end

endmodule

>>> design/strict_utf8_to_utf16_decoder_top.sv
// channel   direction  handshake                 payload
// byte      in         byte_valid / byte_ready   in_byte, final_byte
// unit      out        unit_valid / unit_ready   code_unit, is_replacement, run_end, string_end
//
// a byte is registered, decoded against the sequence state, and its 0..2 units land
// in a two-slot result register; units leave one per cycle while unit_ready is high
// a byte giving a pair holds back the next byte until both its units leave,
// set by the single unit output port draining the result register
// a byte giving no unit (lead or middle continuation) passes with no beat
// arst_n clears the valid flags and the sequence state to no open sequence
// a stalled unit channel holds the result register, then the input register, then byte_ready
module strict_utf8_to_utf16_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  in_byte,
	input  logic        final_byte,
	output logic        unit_valid,
	input  logic        unit_ready,
	output logic [15:0] code_unit,
	output logic        is_replacement,
	output logic        run_end,
	output logic        string_end
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;

	// sequence state
	su8u16_pkg::dec_state_t st_q;
	su8u16_pkg::dec_state_t st_nxt;
	su8u16_pkg::dec_result_t res;

	// result register: count of units and which one is on the port
	logic [1:0]  n_s2;
	logic        pos_s2;
	logic [15:0] u0_s2;
	logic [15:0] u1_s2;
	logic        r0_s2;
	logic        r1_s2;
	logic        fin_s2;

	logic        last_unit;
	logic        s2_free;
	logic        adv;

	assign unit_valid = (n_s2 != 2'd0);
	assign last_unit  = (n_s2 == 2'd1) || pos_s2;
	// result register empties this cycle or already is empty
	assign s2_free    = !unit_valid || (unit_ready && last_unit);
	assign adv        = valid_s1 && s2_free;
	assign byte_ready = !valid_s1 || s2_free;

	su8u16_dec u_dec (
		.st         (st_q),
		.in_byte    (byte_s1),
		.final_byte (fin_s1),
		.nxt        (st_nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= in_byte;
			fin_s1  <= final_byte;
		end
	end

	// state moves only when the registered byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= su8u16_pkg::ST_CLOSED;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s2   <= 2'd0;
			pos_s2 <= 1'b0;
		end else if (adv) begin
			n_s2   <= res.n;
			pos_s2 <= 1'b0;
		end else if (unit_valid && unit_ready) begin
			if (last_unit) begin
				n_s2   <= 2'd0;
				pos_s2 <= 1'b0;
			end else begin
				pos_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u0_s2  <= res.u0;
			u1_s2  <= res.u1;
			r0_s2  <= res.r0;
			r1_s2  <= res.r1;
			fin_s2 <= fin_s1;
		end
	end

	assign code_unit      = pos_s2 ? u1_s2 : u0_s2;
	assign is_replacement = pos_s2 ? r1_s2 : r0_s2;
	assign run_end        = last_unit;
	assign string_end     = last_unit && fin_s2;

endmodule

>>> design/su8u16_checker.sv
`include "strict_utf8_to_utf16_decoder_top_defines.svh"

module su8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        unit_valid,
	input logic        unit_ready,
	input logic [15:0] code_unit,
	input logic        is_replacement,
	input logic        run_end,
	input logic        string_end
);

	`SU8U16_ASSERT_NOW(a_repl_value, unit_valid && is_replacement, code_unit == 16'hFFFD, "replacement beat without FFFD")
	`SU8U16_ASSERT_NOW(a_hi_surr_not_last, unit_valid && code_unit[15:10] == 6'b110110, !run_end && !is_replacement, "high surrogate ends a run")
	`SU8U16_ASSERT_NOW(a_lo_surr_last, unit_valid && code_unit[15:10] == 6'b110111, run_end, "low surrogate not last of run")
	`SU8U16_ASSERT_NEXT(a_stall_hold, unit_valid && !unit_ready, unit_valid && $stable(code_unit) && $stable(string_end), "stalled unit beat changed")

endmodule

bind strict_utf8_to_utf16_decoder_top su8u16_checker u_su8u16_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.unit_valid     (unit_valid),
	.unit_ready     (unit_ready),
	.code_unit      (code_unit),
	.is_replacement (is_replacement),
	.run_end        (run_end),
	.string_end     (string_end)
);
